// ===== hw/rtl/m65enc_pkg.sv =====
// Shared types, field widths and opcode tables for the 6502 instruction encoder.
// No dependencies; used by the channel interfaces, the encode logic and the top level.
package m65enc_pkg;

    localparam int MnW  = 6;
    localparam int ModeW = 4;
    localparam int WordW = 16;
    localparam int LenW = 2;
    localparam int ByteW = 8;

    // Opcode-group codes
    localparam logic [3:0] CLS_ALU    = 4'd0;
    localparam logic [3:0] CLS_SHIFT  = 4'd1;
    localparam logic [3:0] CLS_BIT    = 4'd2;
    localparam logic [3:0] CLS_BRANCH = 4'd3;
    localparam logic [3:0] CLS_IMPL   = 4'd4;
    localparam logic [3:0] CLS_CPX    = 4'd5;
    localparam logic [3:0] CLS_INCDEC = 4'd6;
    localparam logic [3:0] CLS_JMP    = 4'd7;
    localparam logic [3:0] CLS_JSR    = 4'd8;
    localparam logic [3:0] CLS_LDX    = 4'd9;
    localparam logic [3:0] CLS_LDY    = 4'd10;
    localparam logic [3:0] CLS_STA    = 4'd11;
    localparam logic [3:0] CLS_STX    = 4'd12;
    localparam logic [3:0] CLS_STY    = 4'd13;
    localparam logic [3:0] CLS_NONE   = 4'd14;

    // Addressing mode codes
    localparam logic [ModeW-1:0] MODE_IMPL  = 4'd0;
    localparam logic [ModeW-1:0] MODE_IMM   = 4'd1;
    localparam logic [ModeW-1:0] MODE_ZP    = 4'd2;
    localparam logic [ModeW-1:0] MODE_ABS   = 4'd3;
    localparam logic [ModeW-1:0] MODE_ZP_X  = 4'd4;
    localparam logic [ModeW-1:0] MODE_ABS_X = 4'd5;
    localparam logic [ModeW-1:0] MODE_ZP_Y  = 4'd6;
    localparam logic [ModeW-1:0] MODE_ABS_Y = 4'd7;
    localparam logic [ModeW-1:0] MODE_IND   = 4'd8;
    localparam logic [ModeW-1:0] MODE_IND_X = 4'd9;
    localparam logic [ModeW-1:0] MODE_IND_Y = 4'd10;

    localparam logic signed [9:0] BR_MIN = -10'sd128;
    localparam logic signed [9:0] BR_MAX = 10'sd127;

    typedef struct packed {
        logic [3:0]  cls;
        logic [63:0] ops;
    } t_mn_entry;

    typedef struct packed {
        logic [MnW-1:0]   mnemonic;
        logic [ModeW-1:0] mode;
        logic [WordW-1:0] argument;
        logic             second_pass;
        logic [WordW-1:0] location;
    } t_req;

    typedef struct packed {
        logic             error;
        logic [LenW-1:0]  length;
        logic [ByteW-1:0] opcode;
        logic [ByteW-1:0] operand_low;
        logic [ByteW-1:0] operand_high;
    } t_rsp;

    // Group and packed opcode bytes per mnemonic, alphabetical; tail entries are unused codes.
    localparam t_mn_entry MN_TABLE [64] = '{
        '{CLS_ALU,    64'h7161797D6D756569}, '{CLS_ALU,    64'h3121393D2D352529},
        '{CLS_SHIFT,  64'h1E0E16060A},       '{CLS_BRANCH, 64'h90},
        '{CLS_BRANCH, 64'hB0},               '{CLS_BRANCH, 64'hF0},
        '{CLS_BIT,    64'h2C24},             '{CLS_BRANCH, 64'h30},
        '{CLS_BRANCH, 64'hD0},               '{CLS_BRANCH, 64'h10},
        '{CLS_IMPL,   64'h00},               '{CLS_BRANCH, 64'h50},
        '{CLS_BRANCH, 64'h70},               '{CLS_IMPL,   64'h18},
        '{CLS_IMPL,   64'hD8},               '{CLS_IMPL,   64'h58},
        '{CLS_IMPL,   64'hB8},               '{CLS_ALU,    64'hD1C1D9DDCDD5C5C9},
        '{CLS_CPX,    64'hECE4E0},           '{CLS_CPX,    64'hCCC4C0},
        '{CLS_INCDEC, 64'hDECED6C6},         '{CLS_IMPL,   64'hCA},
        '{CLS_IMPL,   64'h88},               '{CLS_ALU,    64'h5141595D4D554549},
        '{CLS_INCDEC, 64'hFEEEF6E6},         '{CLS_IMPL,   64'hE8},
        '{CLS_IMPL,   64'hC8},               '{CLS_JMP,    64'h6C4C},
        '{CLS_JSR,    64'h20},               '{CLS_ALU,    64'hB1A1B9BDADB5A5A9},
        '{CLS_LDX,    64'hBEAEB6A6A2},       '{CLS_LDY,    64'hBCACB4A4A0},
        '{CLS_SHIFT,  64'h5E4E56464A},       '{CLS_IMPL,   64'hEA},
        '{CLS_ALU,    64'h1101191D0D150509}, '{CLS_IMPL,   64'h48},
        '{CLS_IMPL,   64'h08},               '{CLS_IMPL,   64'h68},
        '{CLS_IMPL,   64'h28},               '{CLS_SHIFT,  64'h3E2E36262A},
        '{CLS_SHIFT,  64'h7E6E76666A},       '{CLS_IMPL,   64'h40},
        '{CLS_IMPL,   64'h60},               '{CLS_ALU,    64'hF1E1F9FDEDF5E5E9},
        '{CLS_IMPL,   64'h38},               '{CLS_IMPL,   64'hF8},
        '{CLS_IMPL,   64'h78},               '{CLS_STA,    64'h9181999D8D958500},
        '{CLS_STX,    64'h8E968600},         '{CLS_STY,    64'h8C948400},
        '{CLS_IMPL,   64'hAA},               '{CLS_IMPL,   64'hA8},
        '{CLS_IMPL,   64'hBA},               '{CLS_IMPL,   64'h8A},
        '{CLS_IMPL,   64'h9A},               '{CLS_IMPL,   64'h98},
        '{CLS_NONE,   64'h0},                '{CLS_NONE,   64'h0},
        '{CLS_NONE,   64'h0},                '{CLS_NONE,   64'h0},
        '{CLS_NONE,   64'h0},                '{CLS_NONE,   64'h0},
        '{CLS_NONE,   64'h0},                '{CLS_NONE,   64'h0}
    };

    // One nibble per mode (mode 0 in the low nibble): bit 3 = legal, bits 2:0 = byte slot.
    localparam logic [63:0] SLOT_TABLE [16] = '{
        64'h00000FE0D0CAB980,  // alu
        64'h0000000000CAB908,  // shift
        64'h0000000000009800,  // bit
        64'h0000000000000000,  // branch, decoded apart
        64'h0000000000000008,  // implied
        64'h000000000000A980,  // cpx/cpy
        64'h0000000000B9A800,  // inc/dec
        64'h0000000900008000,  // jmp
        64'h0000000000008000,  // jsr
        64'h00000000CA00B980,  // ldx
        64'h0000000000CAB980,  // ldy
        64'h00000FE0D0CAB900,  // sta
        64'h000000000A00B900,  // stx
        64'h00000000000AB900,  // sty
        64'h0000000000000000,
        64'h0000000000000000
    };

    function automatic logic [LenW-1:0] mode_len(input logic [ModeW-1:0] mode);
        logic [LenW-1:0] len;
        len = 2'd0;
        unique case (mode)
            MODE_IMPL:                                     len = 2'd1;
            MODE_IMM, MODE_ZP, MODE_ZP_X, MODE_ZP_Y,
            MODE_IND_X, MODE_IND_Y:                        len = 2'd2;
            MODE_ABS, MODE_ABS_X, MODE_ABS_Y, MODE_IND:    len = 2'd3;
            default:                                       len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/m65enc_if.sv =====
// Valid/ready channel interfaces for encode requests and encoded results.
// Depends on m65enc_pkg for field widths.
interface m65enc_req_if;
    logic                         valid;
    logic                         ready;
    logic [m65enc_pkg::MnW-1:0]   mnemonic;
    logic [m65enc_pkg::ModeW-1:0] mode;
    logic [m65enc_pkg::WordW-1:0] argument;
    logic                         second_pass;
    logic [m65enc_pkg::WordW-1:0] location;

    modport source(output valid, mnemonic, mode, argument, second_pass, location,
                   input ready);
    modport sink(input valid, mnemonic, mode, argument, second_pass, location,
                 output ready);
endinterface

interface m65enc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         error;
    logic [m65enc_pkg::LenW-1:0]  length;
    logic [m65enc_pkg::ByteW-1:0] opcode;
    logic [m65enc_pkg::ByteW-1:0] operand_low;
    logic [m65enc_pkg::ByteW-1:0] operand_high;

    modport source(output valid, error, length, opcode, operand_low, operand_high,
                   input ready);
    modport sink(input valid, error, length, opcode, operand_low, operand_high,
                 output ready);
endinterface

// ===== hw/rtl/mos6502_instruction_encoder.sv =====
// Top level of the 6502 instruction encoder: input register, encode logic, result register.
// Depends on m65enc_pkg, m65enc_if and m65enc_encode.
//
// Encodes one 6502 instruction per beat: a mnemonic index and addressing mode give the
// opcode, length and operand bytes; branches get argument - location - 2 as an offset,
// range checked on the second pass only. Illegal pairs, unused mnemonic codes and
// out-of-range branches return error with length 0 and all bytes 0. The block takes one
// request per cycle while the result channel is not stalled; a result passes the input register
// and then the result register, each a stage, so a stalled result holds its stage while
// the input stage can still fill. There is no configuration and no state across requests.
module mos6502_instruction_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    m65enc_req_if.sink   i_req,
    m65enc_rsp_if.source o_rsp
);

    logic                  r_in_valid;
    m65enc_pkg::t_req      r_in;
    logic                  r_out_valid;
    m65enc_pkg::t_rsp      r_out;
    m65enc_pkg::t_rsp      n_out;
    logic                  s1_adv;
    logic                  in_rdy;

    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign in_rdy      = !r_in_valid || s1_adv;
    assign i_req.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_rdy) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_req.valid) begin
            r_in.mnemonic    <= i_req.mnemonic;
            r_in.mode        <= i_req.mode;
            r_in.argument    <= i_req.argument;
            r_in.second_pass <= i_req.second_pass;
            r_in.location    <= i_req.location;
        end
    end

    m65enc_encode u_encode (
        .i_req (r_in),
        .o_rsp (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.error        = r_out.error;
    assign o_rsp.length       = r_out.length;
    assign o_rsp.opcode       = r_out.opcode;
    assign o_rsp.operand_low  = r_out.operand_low;
    assign o_rsp.operand_high = r_out.operand_high;

endmodule

// ===== hw/rtl/m65enc_encode.sv =====
// Combinational encode of one registered request: table lookup, branch offset and range check.
// Depends on m65enc_pkg.
module m65enc_encode (
    input  m65enc_pkg::t_req i_req,
    output m65enc_pkg::t_rsp o_rsp
);

    m65enc_pkg::t_mn_entry entry;
    logic [3:0]            slot_nib;
    logic [2:0]            slot;
    logic [1:0]            len;
    logic signed [17:0]    br_diff;
    logic                  br_ok;

    assign entry    = m65enc_pkg::MN_TABLE[i_req.mnemonic];
    assign slot_nib = m65enc_pkg::SLOT_TABLE[entry.cls][{i_req.mode, 2'b00} +: 4];
    assign slot     = slot_nib[2:0];
    assign len      = m65enc_pkg::mode_len(i_req.mode);

    assign br_diff = $signed({2'b00, i_req.argument}) - $signed({2'b00, i_req.location})
                     - 18'sd2;
    assign br_ok   = (br_diff >= 18'(m65enc_pkg::BR_MIN)) &&
                     (br_diff <= 18'(m65enc_pkg::BR_MAX));

    always_comb begin
        o_rsp = '0;
        if (entry.cls == m65enc_pkg::CLS_BRANCH) begin
            if (!i_req.second_pass) begin
                o_rsp.length = 2'd2;
                o_rsp.opcode = entry.ops[7:0];
            end else if (br_ok) begin
                o_rsp.length      = 2'd2;
                o_rsp.opcode      = entry.ops[7:0];
                o_rsp.operand_low = br_diff[7:0];
            end else begin
                o_rsp.error = 1'b1;
            end
        end else if (slot_nib[3]) begin
            o_rsp.length       = len;
            o_rsp.opcode       = entry.ops[{slot, 3'b000} +: 8];
            o_rsp.operand_low  = (len >= 2'd2) ? i_req.argument[7:0] : 8'h00;
            o_rsp.operand_high = (len == 2'd3) ? i_req.argument[15:8] : 8'h00;
        end else begin
            o_rsp.error = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/m65enc_checker.sv =====
// Port-level checks on the encoder's result channel, bound to the top level.
// Depends on mos6502_instruction_encoder and m65enc_pkg.
module m65enc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_error,
    input logic [m65enc_pkg::LenW-1:0]  i_rsp_length,
    input logic [m65enc_pkg::ByteW-1:0] i_rsp_opcode,
    input logic [m65enc_pkg::ByteW-1:0] i_rsp_operand_low,
    input logic [m65enc_pkg::ByteW-1:0] i_rsp_operand_high
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result beat valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_error) &&
            $stable(i_rsp_length) && $stable(i_rsp_opcode) &&
            $stable(i_rsp_operand_low) && $stable(i_rsp_operand_high))
        else $error("stalled result beat changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_error |-> i_rsp_length == 2'd0 && i_rsp_opcode == 8'h00 &&
            i_rsp_operand_low == 8'h00 && i_rsp_operand_high == 8'h00)
        else $error("error beat carries nonzero fields");

    a_len_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_error |-> i_rsp_length != 2'd0 &&
            (i_rsp_length == 2'd3 || i_rsp_operand_high == 8'h00) &&
            (i_rsp_length != 2'd1 || i_rsp_operand_low == 8'h00))
        else $error("operand bytes beyond length or zero length without error");

endmodule

bind mos6502_instruction_encoder m65enc_checker u_m65enc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_error        (o_rsp.error),
    .i_rsp_length       (o_rsp.length),
    .i_rsp_opcode       (o_rsp.opcode),
    .i_rsp_operand_low  (o_rsp.operand_low),
    .i_rsp_operand_high (o_rsp.operand_high)
);

// ===== verif/tb_mos6502_instruction_encoder.sv =====
// Self-checking testbench for mos6502_instruction_encoder: directed and random encode beats
// through the request/result channels, checked against an in-bench opcode and branch predictor.
// Depends on m65enc_pkg, m65enc_if and the encoder RTL.
module tb_mos6502_instruction_encoder;

    typedef logic [m65enc_pkg::MnW-1:0]   t_mn;
    typedef logic [m65enc_pkg::ModeW-1:0] t_mode;
    typedef logic [m65enc_pkg::WordW-1:0] t_word;

    localparam t_mn MN_ADC = 6'd0,  MN_AND = 6'd1,  MN_ASL = 6'd2,  MN_BCC = 6'd3;
    localparam t_mn MN_BCS = 6'd4,  MN_BEQ = 6'd5,  MN_BIT = 6'd6,  MN_BMI = 6'd7;
    localparam t_mn MN_BNE = 6'd8,  MN_BPL = 6'd9,  MN_BRK = 6'd10, MN_BVC = 6'd11;
    localparam t_mn MN_BVS = 6'd12, MN_CLC = 6'd13, MN_CLD = 6'd14, MN_CLI = 6'd15;
    localparam t_mn MN_CLV = 6'd16, MN_CMP = 6'd17, MN_CPX = 6'd18, MN_CPY = 6'd19;
    localparam t_mn MN_DEC = 6'd20, MN_DEX = 6'd21, MN_DEY = 6'd22, MN_EOR = 6'd23;
    localparam t_mn MN_INC = 6'd24, MN_INX = 6'd25, MN_INY = 6'd26, MN_JMP = 6'd27;
    localparam t_mn MN_JSR = 6'd28, MN_LDA = 6'd29, MN_LDX = 6'd30, MN_LDY = 6'd31;
    localparam t_mn MN_LSR = 6'd32, MN_NOP = 6'd33, MN_ORA = 6'd34, MN_PHA = 6'd35;
    localparam t_mn MN_PHP = 6'd36, MN_PLA = 6'd37, MN_PLP = 6'd38, MN_ROL = 6'd39;
    localparam t_mn MN_ROR = 6'd40, MN_RTI = 6'd41, MN_RTS = 6'd42, MN_SBC = 6'd43;
    localparam t_mn MN_SEC = 6'd44, MN_SED = 6'd45, MN_SEI = 6'd46, MN_STA = 6'd47;
    localparam t_mn MN_STX = 6'd48, MN_STY = 6'd49, MN_TAX = 6'd50, MN_TAY = 6'd51;
    localparam t_mn MN_TSX = 6'd52, MN_TXA = 6'd53, MN_TXS = 6'd54, MN_TYA = 6'd55;
    localparam t_mn MN_COUNT = 6'd56;
    localparam t_mn MN_TOP_CODE = {m65enc_pkg::MnW{1'b1}};

    localparam t_mn BRANCH_MN [8] = '{MN_BCC, MN_BCS, MN_BEQ, MN_BMI,
                                     MN_BNE, MN_BPL, MN_BVC, MN_BVS};
    localparam int BRANCH_LO  = -128;
    localparam int BRANCH_HI  = 127;
    localparam int N_ITEMS    = 1650;
    localparam int LONG_HOLD  = 64;

    typedef enum logic [3:0] {
        GRP_ALU, GRP_SHIFT, GRP_BIT, GRP_BRANCH, GRP_IMPL, GRP_CPX, GRP_INCDEC,
        GRP_JMP, GRP_JSR, GRP_LDX, GRP_LDY, GRP_STA, GRP_STX, GRP_STY, GRP_NONE
    } t_enc_grp;

    logic i_clk;
    logic i_rst_n;

    m65enc_req_if req_ch();
    m65enc_rsp_if rsp_ch();

    mos6502_instruction_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    m65enc_pkg::t_req instr_queue[$];
    m65enc_pkg::t_rsp encoded_queue[$];

    int mismatch_cnt;
    int sent_cnt;
    int result_cnt;
    int drain_first;
    int drain_second;

    int burst_left;
    int gap_left;
    logic drv_fire;
    logic drv_valid;

    int rx_cycle;
    int hold_left;
    logic long_hold_done;
    logic rx_ready;
    m65enc_pkg::t_rsp got;
    m65enc_pkg::t_rsp want;

    function automatic m65enc_pkg::t_rsp encode_instr(input m65enc_pkg::t_req r);
        m65enc_pkg::t_rsp res;
        t_enc_grp grp;
        logic [63:0] bank;
        int slot;
        int offs;
        logic [m65enc_pkg::LenW-1:0] nbytes;
        res = '0;
        grp = GRP_NONE;
        bank = '0;
        slot = -1;
        case (r.mnemonic)
            MN_ADC: begin grp = GRP_ALU;    bank = 64'h7161797D6D756569; end
            MN_AND: begin grp = GRP_ALU;    bank = 64'h3121393D2D352529; end
            MN_ASL: begin grp = GRP_SHIFT;  bank = 64'h1E0E16060A; end
            MN_BCC: begin grp = GRP_BRANCH; bank = 64'h90; end
            MN_BCS: begin grp = GRP_BRANCH; bank = 64'hB0; end
            MN_BEQ: begin grp = GRP_BRANCH; bank = 64'hF0; end
            MN_BIT: begin grp = GRP_BIT;    bank = 64'h2C24; end
            MN_BMI: begin grp = GRP_BRANCH; bank = 64'h30; end
            MN_BNE: begin grp = GRP_BRANCH; bank = 64'hD0; end
            MN_BPL: begin grp = GRP_BRANCH; bank = 64'h10; end
            MN_BRK: begin grp = GRP_IMPL;   bank = 64'h00; end
            MN_BVC: begin grp = GRP_BRANCH; bank = 64'h50; end
            MN_BVS: begin grp = GRP_BRANCH; bank = 64'h70; end
            MN_CLC: begin grp = GRP_IMPL;   bank = 64'h18; end
            MN_CLD: begin grp = GRP_IMPL;   bank = 64'hD8; end
            MN_CLI: begin grp = GRP_IMPL;   bank = 64'h58; end
            MN_CLV: begin grp = GRP_IMPL;   bank = 64'hB8; end
            MN_CMP: begin grp = GRP_ALU;    bank = 64'hD1C1D9DDCDD5C5C9; end
            MN_CPX: begin grp = GRP_CPX;    bank = 64'hECE4E0; end
            MN_CPY: begin grp = GRP_CPX;    bank = 64'hCCC4C0; end
            MN_DEC: begin grp = GRP_INCDEC; bank = 64'hDECED6C6; end
            MN_DEX: begin grp = GRP_IMPL;   bank = 64'hCA; end
            MN_DEY: begin grp = GRP_IMPL;   bank = 64'h88; end
            MN_EOR: begin grp = GRP_ALU;    bank = 64'h5141595D4D554549; end
            MN_INC: begin grp = GRP_INCDEC; bank = 64'hFEEEF6E6; end
            MN_INX: begin grp = GRP_IMPL;   bank = 64'hE8; end
            MN_INY: begin grp = GRP_IMPL;   bank = 64'hC8; end
            MN_JMP: begin grp = GRP_JMP;    bank = 64'h6C4C; end
            MN_JSR: begin grp = GRP_JSR;    bank = 64'h20; end
            MN_LDA: begin grp = GRP_ALU;    bank = 64'hB1A1B9BDADB5A5A9; end
            MN_LDX: begin grp = GRP_LDX;    bank = 64'hBEAEB6A6A2; end
            MN_LDY: begin grp = GRP_LDY;    bank = 64'hBCACB4A4A0; end
            MN_LSR: begin grp = GRP_SHIFT;  bank = 64'h5E4E56464A; end
            MN_NOP: begin grp = GRP_IMPL;   bank = 64'hEA; end
            MN_ORA: begin grp = GRP_ALU;    bank = 64'h1101191D0D150509; end
            MN_PHA: begin grp = GRP_IMPL;   bank = 64'h48; end
            MN_PHP: begin grp = GRP_IMPL;   bank = 64'h08; end
            MN_PLA: begin grp = GRP_IMPL;   bank = 64'h68; end
            MN_PLP: begin grp = GRP_IMPL;   bank = 64'h28; end
            MN_ROL: begin grp = GRP_SHIFT;  bank = 64'h3E2E36262A; end
            MN_ROR: begin grp = GRP_SHIFT;  bank = 64'h7E6E76666A; end
            MN_RTI: begin grp = GRP_IMPL;   bank = 64'h40; end
            MN_RTS: begin grp = GRP_IMPL;   bank = 64'h60; end
            MN_SBC: begin grp = GRP_ALU;    bank = 64'hF1E1F9FDEDF5E5E9; end
            MN_SEC: begin grp = GRP_IMPL;   bank = 64'h38; end
            MN_SED: begin grp = GRP_IMPL;   bank = 64'hF8; end
            MN_SEI: begin grp = GRP_IMPL;   bank = 64'h78; end
            MN_STA: begin grp = GRP_STA;    bank = 64'h9181999D8D958500; end
            MN_STX: begin grp = GRP_STX;    bank = 64'h8E968600; end
            MN_STY: begin grp = GRP_STY;    bank = 64'h8C948400; end
            MN_TAX: begin grp = GRP_IMPL;   bank = 64'hAA; end
            MN_TAY: begin grp = GRP_IMPL;   bank = 64'hA8; end
            MN_TSX: begin grp = GRP_IMPL;   bank = 64'hBA; end
            MN_TXA: begin grp = GRP_IMPL;   bank = 64'h8A; end
            MN_TXS: begin grp = GRP_IMPL;   bank = 64'h9A; end
            MN_TYA: begin grp = GRP_IMPL;   bank = 64'h98; end
            default: grp = GRP_NONE;
        endcase

        if (grp == GRP_NONE) begin
            res.error = 1'b1;
            return res;
        end

        // branches ignore the mode code; offset is a plain signed difference
        if (grp == GRP_BRANCH) begin
            offs = int'(r.argument) - int'(r.location) - 2;
            if (!r.second_pass) begin
                res.length = 2'd2;
                res.opcode = bank[7:0];
            end else if (offs < BRANCH_LO || offs > BRANCH_HI) begin
                res.error = 1'b1;
            end else begin
                res.length = 2'd2;
                res.opcode = bank[7:0];
                res.operand_low = offs[7:0];
            end
            return res;
        end

        case (grp)
            GRP_ALU: begin
                case (r.mode)
                    m65enc_pkg::MODE_IMM:   slot = 0;
                    m65enc_pkg::MODE_ZP:    slot = 1;
                    m65enc_pkg::MODE_ZP_X:  slot = 2;
                    m65enc_pkg::MODE_ABS:   slot = 3;
                    m65enc_pkg::MODE_ABS_X: slot = 4;
                    m65enc_pkg::MODE_ABS_Y: slot = 5;
                    m65enc_pkg::MODE_IND_X: slot = 6;
                    m65enc_pkg::MODE_IND_Y: slot = 7;
                    default:                slot = -1;
                endcase
            end
            GRP_STA: begin
                case (r.mode)
                    m65enc_pkg::MODE_ZP:    slot = 1;
                    m65enc_pkg::MODE_ZP_X:  slot = 2;
                    m65enc_pkg::MODE_ABS:   slot = 3;
                    m65enc_pkg::MODE_ABS_X: slot = 4;
                    m65enc_pkg::MODE_ABS_Y: slot = 5;
                    m65enc_pkg::MODE_IND_X: slot = 6;
                    m65enc_pkg::MODE_IND_Y: slot = 7;
                    default:                slot = -1;
                endcase
            end
            GRP_SHIFT: begin
                case (r.mode)
                    m65enc_pkg::MODE_IMPL:  slot = 0;
                    m65enc_pkg::MODE_ZP:    slot = 1;
                    m65enc_pkg::MODE_ZP_X:  slot = 2;
                    m65enc_pkg::MODE_ABS:   slot = 3;
                    m65enc_pkg::MODE_ABS_X: slot = 4;
                    default:                slot = -1;
                endcase
            end
            GRP_BIT: begin
                case (r.mode)
                    m65enc_pkg::MODE_ZP:  slot = 0;
                    m65enc_pkg::MODE_ABS: slot = 1;
                    default:              slot = -1;
                endcase
            end
            GRP_IMPL: slot = (r.mode == m65enc_pkg::MODE_IMPL) ? 0 : -1;
            GRP_CPX: begin
                case (r.mode)
                    m65enc_pkg::MODE_IMM: slot = 0;
                    m65enc_pkg::MODE_ZP:  slot = 1;
                    m65enc_pkg::MODE_ABS: slot = 2;
                    default:              slot = -1;
                endcase
            end
            GRP_INCDEC: begin
                case (r.mode)
                    m65enc_pkg::MODE_ZP:    slot = 0;
                    m65enc_pkg::MODE_ZP_X:  slot = 1;
                    m65enc_pkg::MODE_ABS:   slot = 2;
                    m65enc_pkg::MODE_ABS_X: slot = 3;
                    default:                slot = -1;
                endcase
            end
            GRP_JMP: begin
                case (r.mode)
                    m65enc_pkg::MODE_ABS: slot = 0;
                    m65enc_pkg::MODE_IND: slot = 1;
                    default:              slot = -1;
                endcase
            end
            GRP_JSR: slot = (r.mode == m65enc_pkg::MODE_ABS) ? 0 : -1;
            GRP_LDX: begin
                case (r.mode)
                    m65enc_pkg::MODE_IMM:   slot = 0;
                    m65enc_pkg::MODE_ZP:    slot = 1;
                    m65enc_pkg::MODE_ZP_Y:  slot = 2;
                    m65enc_pkg::MODE_ABS:   slot = 3;
                    m65enc_pkg::MODE_ABS_Y: slot = 4;
                    default:                slot = -1;
                endcase
            end
            GRP_LDY: begin
                case (r.mode)
                    m65enc_pkg::MODE_IMM:   slot = 0;
                    m65enc_pkg::MODE_ZP:    slot = 1;
                    m65enc_pkg::MODE_ZP_X:  slot = 2;
                    m65enc_pkg::MODE_ABS:   slot = 3;
                    m65enc_pkg::MODE_ABS_X: slot = 4;
                    default:                slot = -1;
                endcase
            end
            GRP_STX: begin
                case (r.mode)
                    m65enc_pkg::MODE_ZP:   slot = 1;
                    m65enc_pkg::MODE_ZP_Y: slot = 2;
                    m65enc_pkg::MODE_ABS:  slot = 3;
                    default:               slot = -1;
                endcase
            end
            GRP_STY: begin
                case (r.mode)
                    m65enc_pkg::MODE_ZP:   slot = 1;
                    m65enc_pkg::MODE_ZP_X: slot = 2;
                    m65enc_pkg::MODE_ABS:  slot = 3;
                    default:               slot = -1;
                endcase
            end
            default: slot = -1;
        endcase

        if (slot < 0) begin
            res.error = 1'b1;
            return res;
        end

        case (r.mode)
            m65enc_pkg::MODE_IMPL: nbytes = 2'd1;
            m65enc_pkg::MODE_ABS, m65enc_pkg::MODE_ABS_X,
            m65enc_pkg::MODE_ABS_Y, m65enc_pkg::MODE_IND: nbytes = 2'd3;
            default: nbytes = 2'd2;
        endcase
        res.length = nbytes;
        res.opcode = bank[8*slot +: 8];
        if (nbytes >= 2'd2) res.operand_low = r.argument[7:0];
        if (nbytes == 2'd3) res.operand_high = r.argument[15:8];
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_cnt++;
    endtask

    task automatic queue_instr(input t_mn mn, input t_mode md,
                               input t_word arg, input logic pass,
                               input t_word loc);
        m65enc_pkg::t_req r;
        r.mnemonic = mn;
        r.mode = md;
        r.argument = arg;
        r.second_pass = pass;
        r.location = loc;
        instr_queue.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver: bursts with random gaps, two drain pauses
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left = 0;
        end else begin
            drv_fire = req_ch.valid && req_ch.ready;
            if (drv_fire) begin
                encoded_queue.push_back(encode_instr(instr_queue.pop_front()));
                sent_cnt++;
            end
            if (!(req_ch.valid && !drv_fire)) begin
                drv_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (instr_queue.size() != 0 &&
                             !((sent_cnt == drain_first || sent_cnt == drain_second) &&
                               encoded_queue.size() != 0)) begin
                    drv_valid = 1'b1;
                    req_ch.mnemonic <= instr_queue[0].mnemonic;
                    req_ch.mode <= instr_queue[0].mode;
                    req_ch.argument <= instr_queue[0].argument;
                    req_ch.second_pass <= instr_queue[0].second_pass;
                    req_ch.location <= instr_queue[0].location;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                req_ch.valid <= drv_valid;
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.error = rsp_ch.error;
                got.length = rsp_ch.length;
                got.opcode = rsp_ch.opcode;
                got.operand_low = rsp_ch.operand_low;
                got.operand_high = rsp_ch.operand_high;
                if (encoded_queue.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d arrived with nothing pending", result_cnt));
                end else begin
                    want = encoded_queue.pop_front();
                    if (got.error !== want.error)
                        flag_mismatch($sformatf("beat %0d error %b exp %b",
                                                result_cnt, got.error, want.error));
                    if (got.length !== want.length)
                        flag_mismatch($sformatf("beat %0d length %0d exp %0d",
                                                result_cnt, got.length, want.length));
                    if (got.opcode !== want.opcode)
                        flag_mismatch($sformatf("beat %0d opcode %h exp %h",
                                                result_cnt, got.opcode, want.opcode));
                    if (got.operand_low !== want.operand_low)
                        flag_mismatch($sformatf("beat %0d operand_low %h exp %h",
                                                result_cnt, got.operand_low, want.operand_low));
                    if (got.operand_high !== want.operand_high)
                        flag_mismatch($sformatf("beat %0d operand_high %h exp %h",
                                                result_cnt, got.operand_high,
                                                want.operand_high));
                end
                result_cnt++;
            end

            rx_cycle++;
            if (!long_hold_done && result_cnt >= 300) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_ready = 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0:       rx_ready = ($urandom_range(0, 99) < 60);
                    2:       rx_ready = ($urandom_range(0, 99) < 30);
                    default: rx_ready = 1'b1;
                endcase
            end
            rsp_ch.ready <= rx_ready;
        end
    end

    initial begin
        int n;
        int k;
        int sel;
        int offs;
        m65enc_pkg::t_req rq;

        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mnemonic = '0;
        req_ch.mode = '0;
        req_ch.argument = '0;
        req_ch.second_pass = 1'b0;
        req_ch.location = '0;
        rsp_ch.ready = 1'b0;
        mismatch_cnt = 0;
        sent_cnt = 0;
        result_cnt = 0;

        queue_instr(MN_ADC, m65enc_pkg::MODE_IMM, 16'h00FF, 1'b1, 16'h0200);
        queue_instr(MN_ADC, m65enc_pkg::MODE_ABS, 16'hFFFF, 1'b0, 16'hFFFF);
        queue_instr(MN_ORA, m65enc_pkg::MODE_IND_Y, 16'h0000, 1'b1, 16'h0000);
        queue_instr(MN_LDA, m65enc_pkg::MODE_ABS_Y, 16'h1234, 1'b1, 16'h0400);
        queue_instr(MN_ASL, m65enc_pkg::MODE_IMPL, 16'hABCD, 1'b1, 16'h0400);
        queue_instr(MN_JMP, m65enc_pkg::MODE_IND, 16'hFFFF, 1'b1, 16'h8000);
        queue_instr(MN_JSR, m65enc_pkg::MODE_ABS, 16'h8000, 1'b1, 16'h1000);
        queue_instr(MN_LDX, m65enc_pkg::MODE_ZP_Y, 16'h00EE, 1'b1, 16'h1000);
        queue_instr(MN_TYA, m65enc_pkg::MODE_IMPL, 16'hFFFF, 1'b1, 16'hFFFF);
        queue_instr(MN_BRK, m65enc_pkg::MODE_IMPL, 16'h5555, 1'b0, 16'h0000);
        queue_instr(MN_STA, m65enc_pkg::MODE_IMM, 16'h0012, 1'b1, 16'h0300);
        queue_instr(MN_STX, m65enc_pkg::MODE_ABS_Y, 16'h1234, 1'b1, 16'h0300);
        queue_instr(MN_STY, m65enc_pkg::MODE_ABS_X, 16'h1234, 1'b1, 16'h0300);
        queue_instr(MN_COUNT, m65enc_pkg::MODE_IMPL, 16'h0001, 1'b1, 16'h0300);
        queue_instr(MN_TOP_CODE, m65enc_pkg::MODE_ABS, 16'hFFFF, 1'b1, 16'hFFFF);
        queue_instr(MN_ADC, 4'd11, 16'h0001, 1'b1, 16'h0300);
        queue_instr(MN_NOP, 4'd15, 16'h0001, 1'b1, 16'h0300);
        // first pass: offset zero, no range check
        queue_instr(MN_BCC, 4'd15, 16'hFFFF, 1'b0, 16'h0000);
        queue_instr(MN_BNE, m65enc_pkg::MODE_IMPL, 16'h1000 + 16'd129, 1'b1, 16'h1000);
        queue_instr(MN_BEQ, m65enc_pkg::MODE_ABS_Y, 16'h1000 - 16'd126, 1'b1, 16'h1000);
        queue_instr(MN_BMI, m65enc_pkg::MODE_IMPL, 16'h1000 + 16'd130, 1'b1, 16'h1000);
        queue_instr(MN_BPL, m65enc_pkg::MODE_IMPL, 16'h1000 - 16'd127, 1'b1, 16'h1000);
        // target across address zero is out of range
        queue_instr(MN_BVS, m65enc_pkg::MODE_IMPL, 16'h0002, 1'b1, 16'hFFFE);
        queue_instr(MN_BVC, m65enc_pkg::MODE_IMPL, 16'hFFFF, 1'b1, 16'h0000);
        queue_instr(MN_INC, m65enc_pkg::MODE_ABS_X, 16'h8001, 1'b1, 16'h2000);
        drain_first = instr_queue.size();
        drain_second = drain_first + 800;

        for (n = instr_queue.size(); n < N_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            rq.argument = 16'($urandom_range(0, 16'hFFFF));
            rq.location = 16'($urandom_range(0, 16'hFFFF));
            rq.second_pass = 1'($urandom_range(0, 1));
            if (sel < 12) begin
                rq.mnemonic = 6'($urandom_range(0, MN_TOP_CODE));
                rq.mode = 4'($urandom_range(0, 15));
            end else if (sel < 35) begin
                rq.mnemonic = BRANCH_MN[$urandom_range(0, 7)];
                rq.mode = 4'($urandom_range(0, 15));
                rq.second_pass = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) != 0) begin
                    offs = int'($urandom_range(0, 255)) - 128;
                    rq.argument = 16'(int'(rq.location) + 2 + offs);
                end else if ($urandom_range(0, 1) == 0) begin
                    offs = int'($urandom_range(0, 400)) - 200;
                    rq.argument = 16'(int'(rq.location) + 2 + offs);
                end
            end else begin
                rq.mnemonic = 6'($urandom_range(0, MN_COUNT - 1));
                for (k = 0; k < 40; k++) begin
                    rq.mode = 4'($urandom_range(0, m65enc_pkg::MODE_IND_Y));
                    if (!encode_instr(rq).error) break;
                end
            end
            instr_queue.push_back(rq);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (instr_queue.size() != 0 || encoded_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
